[design/hfl_pkg.sv]
// package for the hex record flash loader
// types, codes, reset values and sizes shared by the queue, parser, sequencer and top
// no dependencies
`default_nettype none
package hfl_pkg;

	localparam int MAX_DATA_BYTES_DEF = 64;

	localparam logic [31:0] APP_START_RST   = 32'h0800_4000;
	localparam logic [31:0] FLASH_LIMIT_RST = 32'h0810_0000;

	localparam logic CFG_APP_START   = 1'b0;
	localparam logic CFG_FLASH_LIMIT = 1'b1;

	localparam logic [7:0] MARKER     = 8'h3A;
	localparam logic [7:0] REC_DATA   = 8'h00;
	localparam logic [7:0] REC_END    = 8'h01;
	localparam logic [7:0] REC_EXT_LA = 8'h04;
	localparam logic [7:0] REC_ST_LA  = 8'h05;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam int CNT_W  = 6;
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef enum logic [2:0] {
		PH_MARK,
		PH_LEN,
		PH_AHI,
		PH_ALO,
		PH_TYPE,
		PH_DATA,
		PH_SUM
	} phase_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_FETCH,
		B_WORD,
		B_STAT
	} bstate_t;

	typedef struct packed {
		logic [31:0]      base;
		logic             bank;
		logic [CNT_W-1:0] count;
		logic             has_status;
		logic [1:0]       status;
	} cmd_t;

endpackage
`default_nettype wire

[design/hfl_if.sv]
// channel interfaces for the hex record flash loader
// byte channel in, result channel out; no dependencies
`default_nettype none
interface hfl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_in_buffer;
	modport source(output valid, data_byte, last_in_buffer, input ready);
	modport sink(input valid, data_byte, last_in_buffer, output ready);
endinterface

interface hfl_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] write_address;
	logic [31:0] write_word;
	logic [1:0]  buffer_status;
	logic        last_of_run;
	modport source(output valid, result_kind, write_address, write_word, buffer_status,
		last_of_run, input ready);
	modport sink(input valid, result_kind, write_address, write_word, buffer_status,
		last_of_run, output ready);
endinterface
`default_nettype wire

[design/hfl_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module hfl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[design/hfl_cmdq.sv]
// short command queue between the record parser and the write sequencer
// depends on hfl_pkg
`default_nettype none
module hfl_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire hfl_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output hfl_pkg::cmd_t      pop_cmd,
	output logic               empty
);

	hfl_pkg::cmd_t              slot_q [hfl_pkg::QDEPTH];
	logic [hfl_pkg::QAW-1:0]    wptr_q;
	logic [hfl_pkg::QAW-1:0]    rptr_q;
	logic [hfl_pkg::QAW:0]      fill_q;

	assign full    = (fill_q == (hfl_pkg::QAW+1)'(hfl_pkg::QDEPTH));
	assign empty   = (fill_q == '0);
	assign pop_cmd = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[design/hfl_front.sv]
// record parser: takes bytes, checks records, fills the word store, queues commands
// depends on hfl_pkg, hfl_if
`default_nettype none
module hfl_front #(
	parameter int MAX_DATA_BYTES = hfl_pkg::MAX_DATA_BYTES_DEF,
	parameter int WIDX_W         = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	hfl_byte_if.sink               byte_ch,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [31:0]       cfg_data,
	output logic                   push,
	output hfl_pkg::cmd_t          push_cmd,
	input  wire logic              q_full,
	input  wire logic              back_busy,
	output logic                   ram_we,
	output logic [WIDX_W:0]        ram_waddr,
	output logic [31:0]            ram_wdata
);

	logic [31:0]      app_start_q;
	logic [31:0]      flash_limit_q;

	hfl_pkg::phase_t  phase_q, phase_n;
	logic [7:0]       count_q, count_n;
	logic [7:0]       len_q, len_n;
	logic [15:0]      offset_q, offset_n;
	logic [7:0]       type_q, type_n;
	logic [7:0]       sum_q, sum_n;
	logic [15:0]      upper_q, upper_n;
	logic [7:0]       up_hi_q, up_hi_n;
	logic [7:0]       up_lo_q, up_lo_n;
	logic [23:0]      acc_q, acc_n;
	logic [7:0]       held_len_q, held_len_n;
	logic             held_bank_q, held_bank_n;
	logic             rec_bank_q, rec_bank_n;
	logic             discard_q, discard_n;
	logic [1:0]       pend_q, pend_n;

	logic             accept;
	logic [7:0]       b;
	logic [31:0]      rec_addr;
	logic [7:0]       sum_chk;
	logic [1:0]       st;

	assign byte_ch.ready = !q_full &&
		!(phase_q == hfl_pkg::PH_DATA && !discard_q && back_busy);
	assign accept   = byte_ch.valid && byte_ch.ready;
	assign b        = byte_ch.data_byte;
	assign rec_addr = {upper_q, offset_q};
	assign sum_chk  = sum_q + b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_start_q   <= hfl_pkg::APP_START_RST;
			flash_limit_q <= hfl_pkg::FLASH_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hfl_pkg::CFG_APP_START:   app_start_q   <= cfg_data;
				hfl_pkg::CFG_FLASH_LIMIT: flash_limit_q <= cfg_data;
				default:                  app_start_q   <= app_start_q;
			endcase
		end
	end

	always_comb begin
		phase_n     = phase_q;
		count_n     = count_q;
		len_n       = len_q;
		offset_n    = offset_q;
		type_n      = type_q;
		sum_n       = sum_q;
		upper_n     = upper_q;
		up_hi_n     = up_hi_q;
		up_lo_n     = up_lo_q;
		acc_n       = acc_q;
		held_len_n  = held_len_q;
		held_bank_n = held_bank_q;
		rec_bank_n  = rec_bank_q;
		discard_n   = discard_q;
		pend_n      = pend_q;
		push        = 1'b0;
		push_cmd    = '0;
		ram_we      = 1'b0;
		ram_waddr   = {rec_bank_q, count_q[WIDX_W+1:2]};
		ram_wdata   = {b, acc_q};
		st          = hfl_pkg::ST_OK;
		if (accept) begin
			if (!discard_q) begin
				case (phase_q)
					hfl_pkg::PH_MARK: begin
						if (b != hfl_pkg::MARKER) begin
							pend_n    = hfl_pkg::ST_BAD;
							discard_n = 1'b1;
							phase_n   = hfl_pkg::PH_MARK;
						end else begin
							sum_n   = '0;
							count_n = '0;
							up_hi_n = '0;
							up_lo_n = '0;
							phase_n = hfl_pkg::PH_LEN;
						end
					end
					hfl_pkg::PH_LEN: begin
						if (b > 8'(MAX_DATA_BYTES)) begin
							pend_n    = hfl_pkg::ST_BAD;
							discard_n = 1'b1;
							phase_n   = hfl_pkg::PH_MARK;
						end else begin
							len_n   = b;
							sum_n   = sum_chk;
							phase_n = hfl_pkg::PH_AHI;
						end
					end
					hfl_pkg::PH_AHI: begin
						offset_n = {b, 8'h00};
						sum_n    = sum_chk;
						phase_n  = hfl_pkg::PH_ALO;
					end
					hfl_pkg::PH_ALO: begin
						offset_n = {offset_q[15:8], b};
						sum_n    = sum_chk;
						phase_n  = hfl_pkg::PH_TYPE;
					end
					hfl_pkg::PH_TYPE: begin
						type_n  = b;
						sum_n   = sum_chk;
						phase_n = (len_q != '0) ? hfl_pkg::PH_DATA : hfl_pkg::PH_SUM;
					end
					hfl_pkg::PH_DATA: begin
						case (count_q[1:0])
							2'd0:    acc_n[7:0]   = b;
							2'd1:    acc_n[15:8]  = b;
							2'd2:    acc_n[23:16] = b;
							default: ram_we       = 1'b1;
						endcase
						if (count_q == 8'd0) begin
							up_hi_n = b;
						end
						if (count_q == 8'd1) begin
							up_lo_n = b;
						end
						sum_n   = sum_chk;
						count_n = count_q + 8'd1;
						if (count_n >= len_q) begin
							phase_n = hfl_pkg::PH_SUM;
						end
					end
					hfl_pkg::PH_SUM: begin
						phase_n = hfl_pkg::PH_MARK;
						if (sum_chk != 8'h00) begin
							pend_n    = hfl_pkg::ST_BAD;
							discard_n = 1'b1;
						end else begin
							case (type_q)
								hfl_pkg::REC_DATA: begin
									if (rec_addr >= flash_limit_q) begin
										pend_n    = hfl_pkg::ST_BAD;
										discard_n = 1'b1;
									end else if (rec_addr == app_start_q) begin
										held_len_n  = len_q;
										held_bank_n = rec_bank_q;
										rec_bank_n  = !rec_bank_q;
									end else begin
										push_cmd.base  = rec_addr;
										push_cmd.bank  = rec_bank_q;
										push_cmd.count = len_q[7:2];
										push           = (len_q[7:2] != '0);
									end
								end
								hfl_pkg::REC_END: begin
									push_cmd.base  = app_start_q;
									push_cmd.bank  = held_bank_q;
									push_cmd.count = held_len_q[7:2];
									push           = (held_len_q[7:2] != '0);
									pend_n         = hfl_pkg::ST_FIN;
									discard_n      = 1'b1;
								end
								hfl_pkg::REC_EXT_LA: upper_n = {up_hi_q, up_lo_q};
								hfl_pkg::REC_ST_LA:  upper_n = upper_q;
								default: begin
									pend_n    = hfl_pkg::ST_BAD;
									discard_n = 1'b1;
								end
							endcase
						end
					end
					default: begin
						pend_n    = hfl_pkg::ST_BAD;
						discard_n = 1'b1;
						phase_n   = hfl_pkg::PH_MARK;
					end
				endcase
			end
			if (byte_ch.last_in_buffer) begin
				st = pend_n;
				if (!discard_n && phase_n != hfl_pkg::PH_MARK) begin
					st = hfl_pkg::ST_BAD;
				end
				push                = 1'b1;
				push_cmd.has_status = 1'b1;
				push_cmd.status     = st;
				phase_n             = hfl_pkg::PH_MARK;
				count_n             = '0;
				discard_n           = 1'b0;
				pend_n              = hfl_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hfl_pkg::PH_MARK;
			count_q     <= '0;
			len_q       <= '0;
			offset_q    <= '0;
			type_q      <= '0;
			sum_q       <= '0;
			upper_q     <= '0;
			up_hi_q     <= '0;
			up_lo_q     <= '0;
			held_len_q  <= '0;
			held_bank_q <= 1'b0;
			rec_bank_q  <= 1'b0;
			discard_q   <= 1'b0;
			pend_q      <= hfl_pkg::ST_OK;
		end else begin
			phase_q     <= phase_n;
			count_q     <= count_n;
			len_q       <= len_n;
			offset_q    <= offset_n;
			type_q      <= type_n;
			sum_q       <= sum_n;
			upper_q     <= upper_n;
			up_hi_q     <= up_hi_n;
			up_lo_q     <= up_lo_n;
			held_len_q  <= held_len_n;
			held_bank_q <= held_bank_n;
			rec_bank_q  <= rec_bank_n;
			discard_q   <= discard_n;
			pend_q      <= pend_n;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_n;
	end

endmodule
`default_nettype wire

[design/hfl_back.sv]
// write sequencer: pops commands, reads stored words, drives the result channel
// depends on hfl_pkg, hfl_if
`default_nettype none
module hfl_back #(
	parameter int WIDX_W = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hfl_pkg::cmd_t pop_cmd,
	input  wire logic          empty,
	output logic               pop,
	output logic               busy,
	output logic               ram_re,
	output logic [WIDX_W:0]    ram_raddr,
	input  wire logic [31:0]   ram_rdata,
	hfl_result_if.source       result_ch
);

	hfl_pkg::bstate_t          state_q, state_n;
	logic [31:0]               addr_q;
	logic                      bank_q;
	logic [hfl_pkg::CNT_W-1:0] cnt_q;
	logic [WIDX_W-1:0]         idx_q;
	logic                      has_st_q;
	logic [1:0]                st_q;
	logic                      word_done;

	assign busy      = (state_q != hfl_pkg::B_IDLE);
	assign ram_raddr = {bank_q, idx_q};
	assign word_done = (state_q == hfl_pkg::B_WORD) && result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hfl_pkg::B_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n                 = state_q;
		pop                     = 1'b0;
		ram_re                  = 1'b0;
		result_ch.valid         = 1'b0;
		result_ch.result_kind   = hfl_pkg::KIND_WRITE;
		result_ch.write_address = addr_q;
		result_ch.write_word    = ram_rdata;
		result_ch.buffer_status = hfl_pkg::ST_OK;
		result_ch.last_of_run   = (cnt_q == hfl_pkg::CNT_W'(1)) && !has_st_q;
		case (state_q)
			hfl_pkg::B_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_n = (pop_cmd.count != '0) ? hfl_pkg::B_FETCH : hfl_pkg::B_STAT;
				end
			end
			hfl_pkg::B_FETCH: begin
				ram_re  = 1'b1;
				state_n = hfl_pkg::B_WORD;
			end
			hfl_pkg::B_WORD: begin
				result_ch.valid = 1'b1;
				if (result_ch.ready) begin
					if (cnt_q > hfl_pkg::CNT_W'(1)) begin
						state_n = hfl_pkg::B_FETCH;
					end else if (has_st_q) begin
						state_n = hfl_pkg::B_STAT;
					end else begin
						state_n = hfl_pkg::B_IDLE;
					end
				end
			end
			hfl_pkg::B_STAT: begin
				result_ch.valid         = 1'b1;
				result_ch.result_kind   = hfl_pkg::KIND_STATUS;
				result_ch.write_address = '0;
				result_ch.write_word    = '0;
				result_ch.buffer_status = st_q;
				result_ch.last_of_run   = 1'b1;
				if (result_ch.ready) begin
					state_n = hfl_pkg::B_IDLE;
				end
			end
			default: state_n = hfl_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q   <= pop_cmd.base;
			bank_q   <= pop_cmd.bank;
			cnt_q    <= pop_cmd.count;
			idx_q    <= '0;
			has_st_q <= pop_cmd.has_status;
			st_q     <= pop_cmd.status;
		end else if (word_done) begin
			addr_q <= addr_q + 32'd4;
			cnt_q  <= cnt_q - 1'b1;
			idx_q  <= idx_q + 1'b1;
		end
	end

	a_word_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hfl_pkg::B_WORD |-> cnt_q != '0)
		else $error("word result with no words left");

	a_fetch_then_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hfl_pkg::B_FETCH |=> state_q == hfl_pkg::B_WORD)
		else $error("fetch not followed by word result");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == hfl_pkg::B_IDLE) && !empty)
		else $error("pop outside idle or from empty queue");

endmodule
`default_nettype wire

[design/hex_record_flash_loader.sv]
// hex record flash loader top: parser, command queue, word store and write sequencer
// depends on hfl_pkg, hfl_if, hfl_ram, hfl_cmdq, hfl_front, hfl_back
// takes one byte a cycle while the command queue has room; bytes in the data phase wait while the sequencer has work
// a buffer's status word is queued with its last byte, then popped by the idle sequencer and sent from its status state
// each word write in the sequencer is a store read in its fetch state, then a result in its word state
// reset: parser at record marker, queue empty, registers at defaults, store not cleared
`default_nettype none
module hex_record_flash_loader #(
	parameter int MAX_DATA_BYTES = hfl_pkg::MAX_DATA_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	hfl_byte_if.sink         byte_ch,
	hfl_result_if.source     result_ch,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int STORE_WORDS = (MAX_DATA_BYTES + 3) / 4;
	localparam int WIDX_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int RAM_DEPTH   = 2 * (2 ** WIDX_W);

	logic          push;
	hfl_pkg::cmd_t push_cmd;
	logic          q_full;
	logic          pop;
	hfl_pkg::cmd_t pop_cmd;
	logic          q_empty;
	logic          back_busy;
	logic          ram_we;
	logic [WIDX_W:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [WIDX_W:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic          busy_any;

	assign busy_any = back_busy || !q_empty;

	hfl_front #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES),
		.WIDX_W(WIDX_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.push_cmd(push_cmd),
		.q_full(q_full),
		.back_busy(busy_any),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	hfl_cmdq u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(pop),
		.pop_cmd(pop_cmd),
		.empty(q_empty)
	);

	hfl_ram #(
		.WIDTH(32),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	hfl_back #(
		.WIDX_W(WIDX_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_cmd(pop_cmd),
		.empty(q_empty),
		.pop(pop),
		.busy(back_busy),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.result_ch(result_ch)
	);

endmodule
`default_nettype wire
